[hw/rtl/s2ok_pkg.sv]
// Shared types, fixed-point coefficients and the sRGB decode function used to
// build the linearization ROM for the sRGB to OKLab pixel core.
// No dependencies.
package s2ok_pkg;

  localparam int FRAC   = 30;          // Q30 fraction bits of linear, LMS and root values
  localparam int Q_W    = FRAC + 1;    // room for exactly 1.0
  localparam int LMS_CW = 24;          // unsigned Q24 coefficients of the first matrix
  localparam int LAB_CW = 28;          // signed Q24 coefficients of the second matrix

  localparam longint ONE = longint'(1) << FRAC;

  typedef logic [Q_W-1:0]          q30_t;
  typedef logic [2:0][Q_W-1:0]     q30x3_t;

  // round(n * 2^24 / 10^10) for a ten-decimal constant
  function automatic longint cq(input longint n);
    return (n * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
  endfunction

  localparam logic [LMS_CW-1:0] LMS_COEF [3][3] = '{
    '{LMS_CW'(cq(64'sd4122214708)), LMS_CW'(cq(64'sd5363325363)),
      LMS_CW'(cq(64'sd514459929))},
    '{LMS_CW'(cq(64'sd2119034982)), LMS_CW'(cq(64'sd6806995451)),
      LMS_CW'(cq(64'sd1073969566))},
    '{LMS_CW'(cq(64'sd883024619)),  LMS_CW'(cq(64'sd2817188376)),
      LMS_CW'(cq(64'sd6299787005))}
  };

  localparam logic signed [LAB_CW-1:0] LAB_COEF [3][3] = '{
    '{LAB_CW'(cq(64'sd2104542553)),  LAB_CW'(cq(64'sd7936177850)),
      LAB_CW'(-cq(64'sd40720468))},
    '{LAB_CW'(cq(64'sd19779984951)), LAB_CW'(-cq(64'sd24285922050)),
      LAB_CW'(cq(64'sd4505937099))},
    '{LAB_CW'(cq(64'sd259040371)),   LAB_CW'(cq(64'sd7827717662)),
      LAB_CW'(-cq(64'sd8086757660))}
  };

  // Upper clamp of lightness for a given number of fraction bits
  function automatic int l_max(input int frac_bits);
    return (frac_bits >= 16) ? 65535 : (1 << frac_bits);
  endfunction

  // r^k in Q30, truncating after each multiply
  function automatic longint pow_q30(input longint r, input int k);
    longint p;
    p = r;
    for (int i = 1; i < k; i++) begin
      p = (p * r) >>> FRAC;
    end
    return p;
  endfunction

  // Largest r in [0, 1.0] with pow_q30(r, 5) <= x
  function automatic longint root5_q30(input longint x);
    longint lo, hi, mid;
    lo = 0;
    hi = ONE;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >>> 1);
        if (pow_q30(mid, 5) <= x) lo = mid;
        else hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // sRGB code value to linear light, Q30; evaluated only for ROM contents
  function automatic longint decode_lin(input int v);
    longint vv, t, u, r;
    vv = longint'(v);
    if (vv <= 10) return (vv * 100 * ONE) / 64'sd329460;
    t = ((1000 * vv + 14025) * ONE + 134512) / 64'sd269025;
    u = (t * t) >>> FRAC;
    r = root5_q30(u);
    return (u * r) >>> FRAC;
  endfunction

endpackage

[hw/rtl/s2ok_lin.sv]
// Linearization stage: one registered lookup per channel into a constant
// 256-entry Q30 table. Depends on s2ok_pkg.
module s2ok_lin (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  output logic             dn_valid,
  input  logic             dn_ready,
  output s2ok_pkg::q30x3_t lin
);

  s2ok_pkg::q30_t   rom [256];
  s2ok_pkg::q30x3_t lin_r;
  logic             v_r;
  logic             en;

  for (genvar g = 0; g < 256; g++) begin : g_rom
    assign rom[g] = s2ok_pkg::q30_t'(s2ok_pkg::decode_lin(g));
  end

  assign en       = ~v_r | dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign lin      = lin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= rom[red];
      lin_r[1] <= rom[green];
      lin_r[2] <= rom[blue];
    end
  end

endmodule

[hw/rtl/s2ok_lms.sv]
// RGB to LMS matrix: products in the first stage, row sums with rounding
// and clamp to [0, 1.0] in the second. Depends on s2ok_pkg.
module s2ok_lms (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  s2ok_pkg::q30x3_t lin,
  output logic             dn_valid,
  input  logic             dn_ready,
  output s2ok_pkg::q30x3_t lms
);

  localparam int PW = s2ok_pkg::Q_W + s2ok_pkg::LMS_CW;
  localparam int SW = PW + 2;
  localparam int RW = SW - 24;

  logic [PW-1:0]    prod_nxt [3][3];
  logic [PW-1:0]    prod_r   [3][3];
  s2ok_pkg::q30x3_t lms_nxt;
  s2ok_pkg::q30x3_t lms_r;
  logic [1:0]       v_r;
  logic [1:0]       en;
  logic [SW-1:0]    sum;
  logic [RW-1:0]    shr;

  assign en[1]    = ~v_r[1] | dn_ready;
  assign en[0]    = ~v_r[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[1];
  assign lms      = lms_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = PW'(lin[j]) * PW'(s2ok_pkg::LMS_COEF[i][j]);
      end
    end
  end

  always_comb begin
    sum     = '0;
    shr     = '0;
    lms_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sum = SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]) + (SW'(1) << 23);
      shr = sum[SW-1:24];
      lms_nxt[i] = (shr > RW'(s2ok_pkg::ONE)) ? s2ok_pkg::q30_t'(s2ok_pkg::ONE)
                                              : shr[s2ok_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) prod_r <= prod_nxt;
    if (en[1]) lms_r  <= lms_nxt;
  end

endmodule

[hw/rtl/s2ok_cbrt.sv]
// Pipelined cube root of three Q30 lanes: one result bit per stage, most
// significant first, with the exact square carried forward. Depends on s2ok_pkg.
module s2ok_cbrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  s2ok_pkg::q30x3_t lms,
  output logic             dn_valid,
  input  logic             dn_ready,
  output s2ok_pkg::q30x3_t root
);

  localparam int NSTG = s2ok_pkg::FRAC;
  localparam int CW   = s2ok_pkg::FRAC;
  localparam int SQW  = 2 * CW;

  logic [CW-1:0]          c_r    [NSTG][3];
  logic [SQW-1:0]         sq_r   [NSTG][3];
  s2ok_pkg::q30_t         x_r    [NSTG][3];
  logic [CW-1:0]          c_nxt  [NSTG][3];
  logic [SQW-1:0]         sq_nxt [NSTG][3];
  logic [CW-1:0]          c_in   [NSTG][3];
  logic [SQW-1:0]         sq_in  [NSTG][3];
  s2ok_pkg::q30_t         x_in   [NSTG][3];
  logic [NSTG-1:0]        v_r;
  logic [NSTG-1:0]        en;

  always_comb begin
    en[NSTG-1] = ~v_r[NSTG-1] | dn_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = ~v_r[s] | en[s+1];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NSTG-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      c_in[0][l]  = '0;
      sq_in[0][l] = '0;
      x_in[0][l]  = lms[l];
    end
    for (int s = 1; s < NSTG; s++) begin
      for (int l = 0; l < 3; l++) begin
        c_in[s][l]  = c_r[s-1][l];
        sq_in[s][l] = sq_r[s-1][l];
        x_in[s][l]  = x_r[s-1][l];
      end
    end
  end

  // Try setting bit k: (c + 2^k)^2 = c^2 + c*2^(k+1) + 2^(2k), then one multiply
  always_comb begin
    logic [CW-1:0]  trial;
    logic [SQW-1:0] tsq;
    logic [SQW-1:0] prod;
    int             k;
    for (int s = 0; s < NSTG; s++) begin
      k = NSTG - 1 - s;
      for (int l = 0; l < 3; l++) begin
        trial = c_in[s][l] | (CW'(1) << k);
        tsq   = sq_in[s][l] + (SQW'(c_in[s][l]) << (k + 1)) + (SQW'(1) << (2 * k));
        prod  = SQW'(tsq[SQW-1:CW]) * SQW'(trial);
        if ({1'b0, prod[SQW-1:CW]} <= x_in[s][l]) begin
          c_nxt[s][l]  = trial;
          sq_nxt[s][l] = tsq;
        end else begin
          c_nxt[s][l]  = c_in[s][l];
          sq_nxt[s][l] = sq_in[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (en[s]) v_r[s] <= (s == 0) ? up_valid : v_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (en[s]) begin
        for (int l = 0; l < 3; l++) begin
          c_r[s][l]  <= c_nxt[s][l];
          sq_r[s][l] <= sq_nxt[s][l];
          x_r[s][l]  <= x_in[s][l];
        end
      end
    end
  end

  // An input of exactly 1.0 has root 1.0, outside the bit-serial range
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      root[l] = (x_r[NSTG-1][l] == s2ok_pkg::q30_t'(s2ok_pkg::ONE))
              ? s2ok_pkg::q30_t'(s2ok_pkg::ONE) : {1'b0, c_r[NSTG-1][l]};
    end
  end

endmodule

[hw/rtl/s2ok_lab.sv]
// LMS' to Lab matrix: signed products, row sums, then rounding half away from
// zero to the output scale and saturation. Depends on s2ok_pkg.
module s2ok_lab #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  s2ok_pkg::q30x3_t   root,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic        [15:0] lightness,
  output logic signed [15:0] green_red,
  output logic signed [15:0] blue_yellow
);

  localparam int PW = s2ok_pkg::Q_W + 1 + s2ok_pkg::LAB_CW;
  localparam int SW = PW + 2;
  localparam int SH = 54 - OUT_FRAC_BITS;
  localparam logic        [SW-1:0] HALF  = SW'(1) << (SH - 1);
  localparam logic signed [SW-1:0] L_TOP = SW'(s2ok_pkg::l_max(OUT_FRAC_BITS));
  localparam logic signed [SW-1:0] O_TOP = SW'(32767);
  localparam logic signed [SW-1:0] O_BOT = SW'(-32768);

  logic signed [PW-1:0] prod_nxt [3][3];
  logic signed [PW-1:0] prod_r   [3][3];
  logic signed [SW-1:0] sum_r    [3];
  logic signed [SW-1:0] val      [3];
  logic        [15:0]   l_nxt;
  logic signed [15:0]   a_nxt;
  logic signed [15:0]   b_nxt;
  logic        [15:0]   l_r;
  logic signed [15:0]   a_r;
  logic signed [15:0]   b_r;
  logic        [2:0]    v_r;
  logic        [2:0]    en;

  assign en[2]       = ~v_r[2] | dn_ready;
  assign en[1]       = ~v_r[1] | en[2];
  assign en[0]       = ~v_r[0] | en[1];
  assign up_ready    = en[0];
  assign dn_valid    = v_r[2];
  assign lightness   = l_r;
  assign green_red   = a_r;
  assign blue_yellow = b_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = PW'($signed({1'b0, root[j]})) * PW'(s2ok_pkg::LAB_COEF[i][j]);
      end
    end
  end

  always_comb begin
    logic          neg;
    logic [SW-1:0] mag;
    logic [SW-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      neg    = sum_r[i][SW-1];
      mag    = neg ? (~sum_r[i] + SW'(1)) : sum_r[i];
      rnd    = (mag + HALF) >> SH;
      val[i] = neg ? -$signed(rnd) : $signed(rnd);
    end
  end

  always_comb begin
    if (val[0] < 0) l_nxt = '0;
    else if (val[0] > L_TOP) l_nxt = L_TOP[15:0];
    else l_nxt = val[0][15:0];
    if (val[1] < O_BOT) a_nxt = O_BOT[15:0];
    else if (val[1] > O_TOP) a_nxt = O_TOP[15:0];
    else a_nxt = val[1][15:0];
    if (val[2] < O_BOT) b_nxt = O_BOT[15:0];
    else if (val[2] > O_TOP) b_nxt = O_TOP[15:0];
    else b_nxt = val[2][15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) prod_r <= prod_nxt;
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]);
      end
    end
    if (en[2]) begin
      l_r <= l_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

endmodule

[hw/rtl/srgb_to_oklab_pixel_core.sv]
// sRGB to OKLab pixel core: takes one 8-bit sRGB pixel per beat and returns
// OKLab L, a, b. Accepts one pixel every clock when the output is not stalled.
// Its stages, in order: the linearization ROM, the RGB to LMS matrix, the cube
// root (one result bit per stage on each of three lanes), and the Lab matrix
// with rounding and saturation. Every stage has its own valid bit and a stall
// fills empty stages before input is held.
// Depends on s2ok_pkg, s2ok_lin, s2ok_lms, s2ok_cbrt and s2ok_lab.
module srgb_to_oklab_pixel_core #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [7:0]  in_red,
  input  logic        [7:0]  in_green,
  input  logic        [7:0]  in_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [15:0] out_lightness,
  output logic signed [15:0] out_green_red,
  output logic signed [15:0] out_blue_yellow
);

  s2ok_pkg::q30x3_t lin;
  s2ok_pkg::q30x3_t lms;
  s2ok_pkg::q30x3_t root;
  logic             lin_valid, lin_ready;
  logic             lms_valid, lms_ready;
  logic             root_valid, root_ready;

  s2ok_lin u_lin (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (lin_valid),
    .dn_ready (lin_ready),
    .lin      (lin)
  );

  s2ok_lms u_lms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lin_valid),
    .up_ready (lin_ready),
    .lin      (lin),
    .dn_valid (lms_valid),
    .dn_ready (lms_ready),
    .lms      (lms)
  );

  s2ok_cbrt u_cbrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lms_valid),
    .up_ready (lms_ready),
    .lms      (lms),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .root     (root)
  );

  s2ok_lab #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_lab (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (root_valid),
    .up_ready    (root_ready),
    .root        (root),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .lightness   (out_lightness),
    .green_red   (out_green_red),
    .blue_yellow (out_blue_yellow)
  );

`ifndef SYNTH
  // An empty output stage means every stage can advance
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held while output stage empty");

  a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lightness <= 16'(s2ok_pkg::l_max(OUT_FRAC_BITS))))
    else $error("lightness above saturation limit");

  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

[verif/tb_srgb_to_oklab_pixel_core.sv]
// Self-checking testbench for srgb_to_oklab_pixel_core: directed and random sRGB pixels,
// bursty input, stalling output, scored against an in-bench fixed-point OKLab predictor.
// Depends only on the core RTL and its package.
`timescale 1ns / 100ps

class oklab_scoreboard;
  localparam int FRAC_BITS = 15;
  localparam longint UNITY = longint'(1) << 30;

  longint lin_rom [256];
  longint rgb_lms [3][3];
  longint lms_lab [3][3];
  logic [15:0] exp_l [$];
  logic [15:0] exp_a [$];
  logic [15:0] exp_b [$];
  int errors;
  int pixels_seen;
  int results_seen;

  function new();
    longint t, u, r;
    rgb_lms = '{'{q24(64'sd4122214708), q24(64'sd5363325363), q24(64'sd514459929)},
                '{q24(64'sd2119034982), q24(64'sd6806995451), q24(64'sd1073969566)},
                '{q24(64'sd883024619),  q24(64'sd2817188376), q24(64'sd6299787005)}};
    lms_lab = '{'{q24(64'sd2104542553),  q24(64'sd7936177850),   -q24(64'sd40720468)},
                '{q24(64'sd19779984951), -q24(64'sd24285922050), q24(64'sd4505937099)},
                '{q24(64'sd259040371),   q24(64'sd7827717662),   -q24(64'sd8086757660)}};
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        lin_rom[v] = (longint'(v) * 100 * UNITY) / 329460;
      end else begin
        t = ((1000 * longint'(v) + 14025) * UNITY + 134512) / 269025;
        u = (t * t) >>> 30;
        r = int_root(u, 5);
        lin_rom[v] = (u * r) >>> 30;
      end
    end
    errors = 0;
    pixels_seen = 0;
    results_seen = 0;
  endfunction

  function longint q24(longint n);
    return (n * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
  endfunction

  // truncate after every multiply, as the datapath does
  function longint trunc_pow(longint x, int k);
    longint p;
    p = x;
    for (int i = 1; i < k; i++) p = (p * x) >>> 30;
    return p;
  endfunction

  function longint int_root(longint x, int k);
    longint lo, hi, mid;
    lo = 0;
    hi = UNITY;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (trunc_pow(mid, k) <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    longint lin [3];
    longint cr [3];
    longint lab [3];
    longint acc, half;
    int sh;
    lin = '{lin_rom[red], lin_rom[green], lin_rom[blue]};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rgb_lms[i][j] * lin[j];
      cr[i] = int_root(clip((acc + (longint'(1) << 23)) >>> 24, 0, UNITY), 3);
    end
    sh = 54 - FRAC_BITS;
    half = longint'(1) << (sh - 1);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += lms_lab[i][j] * cr[j];
      lab[i] = (acc < 0) ? -(((-acc) + half) >>> sh) : ((acc + half) >>> sh);
    end
    exp_l.push_back(16'(clip(lab[0], 0, FRAC_BITS >= 16 ? 65535 : (1 << FRAC_BITS))));
    exp_a.push_back(16'(clip(lab[1], -32768, 32767)));
    exp_b.push_back(16'(clip(lab[2], -32768, 32767)));
    pixels_seen++;
  endfunction

  function void check_result(logic [15:0] l, logic [15:0] a, logic [15:0] b);
    logic [15:0] el, ea, eb;
    results_seen++;
    if (exp_l.size() == 0) begin
      $error("result beat with no pixel pending: L=%0h a=%0h b=%0h", l, a, b);
      errors++;
      return;
    end
    el = exp_l.pop_front();
    ea = exp_a.pop_front();
    eb = exp_b.pop_front();
    if (l !== el) begin
      $error("lightness: expected %0d, got %0d", el, l);
      errors++;
    end
    if (a !== ea) begin
      $error("green_red: expected %0d, got %0d", $signed(ea), $signed(a));
      errors++;
    end
    if (b !== eb) begin
      $error("blue_yellow: expected %0d, got %0d", $signed(eb), $signed(b));
      errors++;
    end
  endfunction

  function int pending();
    return exp_l.size();
  endfunction
endclass

module tb_srgb_to_oklab_pixel_core;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_lightness;
  logic signed [15:0] out_green_red;
  logic signed [15:0] out_blue_yellow;

  oklab_scoreboard sb = new();
  int hold_cycles = 0;    // long receiver hold-off, requested by the stimulus
  int stall_mode = 0;

  srgb_to_oklab_pixel_core #(.OUT_FRAC_BITS(15)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_lightness(out_lightness), .out_green_red(out_green_red),
    .out_blue_yellow(out_blue_yellow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_pixel(in_red, in_green, in_blue);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_lightness, out_green_red, out_blue_yellow);
  end

  // receiver: long hold-off when asked, else a stall pattern that changes mode
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3, 0) != 0);
        2: out_ready <= ($urandom_range(1, 0) != 0);
        default: out_ready <= ($urandom_range(4, 0) == 0);
      endcase
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(3, 0);
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(5, 0))
      0: return 8'($urandom_range(12, 0));    // around the linear-segment knee
      1: return 8'($urandom_range(255, 240));
      2: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  initial begin
    #400_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: black, white, primaries, secondaries, grays, the knee at 10/11
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd10, 8'd11, 8'd0);
    send_pixel(8'd0, 8'd10, 8'd11);
    send_pixel(8'd254, 8'd1, 8'd254);
    send_pixel(8'd1, 8'd254, 8'd1);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    drain();

    // random bursts
    for (int burst = 0; burst < 60; burst++) begin
      int len;
      len = $urandom_range(30, 1);
      if (burst == 20) begin
        // hold off the receiver while the sender keeps pushing; the core must back up
        hold_cycles = 150;
        len = 90;
      end
      for (int k = 0; k < len; k++) begin
        send_pixel(pick_code(), pick_code(), pick_code());
        if ($urandom_range(9, 0) == 0) idle_gap($urandom_range(3, 1));
      end
      if (burst == 40) drain();
      else if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(20, 1));
    end

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d pixels (directed extremes, knee codes, random bursts) with %0d results",
             sb.pixels_seen, sb.results_seen);
    $display("input backpressure exercised by a long output hold-off and random stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/s2ok_pkg.sv
hw/rtl/s2ok_lin.sv
hw/rtl/s2ok_lms.sv
hw/rtl/s2ok_cbrt.sv
hw/rtl/s2ok_lab.sv
hw/rtl/srgb_to_oklab_pixel_core.sv
verif/tb_srgb_to_oklab_pixel_core.sv
